// File: rtl/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
package bole_pkg;

  localparam int DepthDefault = 16;
  localparam int DataW        = 32;
  localparam int PosW         = 5;
  localparam int IdxMaxW      = 6;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_END   = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_SEARCH    = 3'd6,
    REQ_READ_ALL  = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ROT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [IdxMaxW-1:0]   idx;
    logic [IdxMaxW-1:0]   last;
    logic [DataW-1:0]     value;
  } cell_cmd_t;

endpackage

// File: rtl/bounded_ordered_list_engine.sv
// Bounded ordered list engine: a shifting row of cells plus its sequencer.
// Insert: result in the cycle after accept; inserts may follow every cycle while the output is not stalled.
// Delete and search: a full rotation of the occupied cells per request.
// Read-all: one word per cycle from the head cell while the output is not stalled, count words, last marked.
// Reset clears the state, the entry count and the output valid flag; cell contents are left
// as they are, no clearing pass is needed.
module bounded_ordered_list_engine #(
  parameter int DEPTH = bole_pkg::DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[4:0], value[36:5]
  input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_value[31:0], out_position[36:32], item_count[41:37]
  output logic [2:0]  m_axis_tuser,  // status[2:0]
  output logic        m_axis_tlast
);
  import bole_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = ((CW > PosW) ? CW : PosW) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  req_e             req_q, req_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    scan_q, scan_d;
  logic [DataW-1:0] val_q, val_d;
  logic             found_q, found_d;
  logic [IW-1:0]    fpos_q, fpos_d;

  logic             m_valid_q, m_valid_d;
  status_e          m_status_q, m_status_d;
  logic [DataW-1:0] m_value_q, m_value_d;
  logic [PosW-1:0]  m_pos_q, m_pos_d;
  logic [PosW-1:0]  m_cnt_q, m_cnt_d;
  logic             m_last_q, m_last_d;

  cell_cmd_t        cmd;
  logic [DataW-1:0] cell_data [DEPTH];

  req_e             in_req;
  logic [PosW-1:0]  in_pos;
  logic [DataW-1:0] in_val;
  logic             out_free, acc;
  logic [CMPW-1:0]  pos_x, count_x, pos_m1;
  logic [CW-1:0]    cnt_m1;
  logic [IW-1:0]    cnt_last, ins_idx;
  logic             ins_bad, del_bad, full, empty;

  assign in_req   = req_e'(s_axis_tuser);
  assign in_pos   = s_axis_tdata[4:0];
  assign in_val   = s_axis_tdata[36:5];
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign acc      = s_axis_tvalid && s_axis_tready;

  assign pos_x    = CMPW'(in_pos);
  assign count_x  = CMPW'(count_q);
  assign pos_m1   = pos_x - 1'b1;
  assign cnt_m1   = count_q - 1'b1;
  assign cnt_last = cnt_m1[IW-1:0];
  assign ins_bad  = (in_pos == '0) || (pos_x > count_x + 1'b1);
  assign del_bad  = (in_pos == '0) || (pos_x > count_x);
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);

  always_comb begin
    case (in_req)
      REQ_INS_FRONT: ins_idx = '0;
      REQ_INS_END:   ins_idx = count_q[IW-1:0];
      default:       ins_idx = pos_m1[IW-1:0];
    endcase
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    req_d      = req_q;
    idx_d      = idx_q;
    scan_d     = scan_q;
    val_d      = val_q;
    found_d    = found_q;
    fpos_d     = fpos_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_status_d = m_status_q;
    m_value_d  = m_value_q;
    m_pos_d    = m_pos_q;
    m_cnt_d    = m_cnt_q;
    m_last_d   = m_last_q;
    cmd.op     = CMD_HOLD;
    cmd.idx    = IdxMaxW'(idx_q);
    cmd.last   = IdxMaxW'(cnt_last);
    cmd.value  = in_val;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          m_valid_d = 1'b1;
          m_last_d  = 1'b1;
          m_pos_d   = '0;
          m_cnt_d   = PosW'(count_q);
          case (in_req)
            REQ_INS_FRONT, REQ_INS_END, REQ_INS_POS: begin
              m_value_d = in_val;
              if ((in_req == REQ_INS_POS) && ins_bad) begin
                m_status_d = ST_BAD_POS;
              end else if (full) begin
                m_status_d = ST_FULL;
              end else begin
                cmd.op     = CMD_INS;
                cmd.idx    = IdxMaxW'(ins_idx);
                count_d    = count_q + 1'b1;
                m_status_d = ST_OK;
                m_pos_d    = PosW'({1'b0, ins_idx} + 1'b1);
                m_cnt_d    = PosW'(count_d);
              end
            end
            REQ_DEL_FRONT, REQ_DEL_END, REQ_DEL_POS: begin
              m_value_d = '0;
              if (empty) begin
                m_status_d = ST_EMPTY;
              end else if ((in_req == REQ_DEL_POS) && del_bad) begin
                m_status_d = ST_BAD_POS;
              end else begin
                m_valid_d = m_valid_q && !m_axis_tready;
                req_d     = in_req;
                scan_d    = '0;
                state_d   = S_SCAN;
                case (in_req)
                  REQ_DEL_FRONT: idx_d = '0;
                  REQ_DEL_END:   idx_d = cnt_last;
                  default:       idx_d = pos_m1[IW-1:0];
                endcase
              end
            end
            REQ_SEARCH: begin
              m_value_d = in_val;
              if (empty) begin
                m_status_d = ST_EMPTY;
              end else begin
                m_valid_d = m_valid_q && !m_axis_tready;
                req_d     = in_req;
                val_d     = in_val;
                found_d   = 1'b0;
                scan_d    = '0;
                state_d   = S_SCAN;
              end
            end
            REQ_READ_ALL: begin
              m_value_d = '0;
              if (empty) begin
                m_status_d = ST_EMPTY;
              end else begin
                m_valid_d = m_valid_q && !m_axis_tready;
                req_d     = in_req;
                scan_d    = '0;
                state_d   = S_SCAN;
              end
            end
            default: m_status_d = ST_EMPTY;
          endcase
        end
      end
      S_SCAN: begin
        if ((req_q != REQ_READ_ALL) || out_free) begin
          cmd.op = CMD_ROT;
          scan_d = scan_q + 1'b1;
          if ((req_q == REQ_SEARCH) && !found_q && (cell_data[0] == val_q)) begin
            found_d = 1'b1;
            fpos_d  = scan_q;
          end
          if ((req_q != REQ_SEARCH) && (req_q != REQ_READ_ALL) && (scan_q == idx_q)) begin
            val_d = cell_data[0];
          end
          if (req_q == REQ_READ_ALL) begin
            m_valid_d  = 1'b1;
            m_status_d = ST_OK;
            m_value_d  = cell_data[0];
            m_pos_d    = PosW'({1'b0, scan_q} + 1'b1);
            m_cnt_d    = PosW'(count_q);
            m_last_d   = (scan_q == cnt_last);
          end
          if (scan_q == cnt_last) begin
            state_d = (req_q == REQ_READ_ALL) ? S_IDLE : S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_last_d  = 1'b1;
          m_value_d = val_q;
          state_d   = S_IDLE;
          if (req_q == REQ_SEARCH) begin
            m_cnt_d = PosW'(count_q);
            if (found_q) begin
              m_status_d = ST_OK;
              m_pos_d    = PosW'({1'b0, fpos_q} + 1'b1);
            end else begin
              m_status_d = ST_NOT_FOUND;
              m_pos_d    = '0;
            end
          end else begin
            cmd.op     = CMD_DEL;
            count_d    = count_q - 1'b1;
            m_status_d = ST_OK;
            m_pos_d    = PosW'({1'b0, idx_q} + 1'b1);
            m_cnt_d    = PosW'(count_d);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    scan_q     <= scan_d;
    val_q      <= val_d;
    found_q    <= found_d;
    fpos_q     <= fpos_d;
    m_status_q <= m_status_d;
    m_value_q  <= m_value_d;
    m_pos_q    <= m_pos_d;
    m_cnt_q    <= m_cnt_d;
    m_last_q   <= m_last_d;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_body
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_next
      assign right_w = cell_data[g+1];
    end
    bole_cell #(
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .wrap_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_cnt_q, m_pos_q, m_value_q};
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == S_IDLE))
    else $error("request taken while busy");

  a_mid_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (state_q == S_SCAN && req_q == REQ_READ_ALL))
    else $error("non-final word outside a read-out");

  a_count_stable_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> $stable(count_q))
    else $error("count changed during rotation");

endmodule

// File: rtl/bole_cell.sv
// One list cell: holds a word, moves words to or from its neighbors, or loads an inserted or wrapped word.
module bole_cell #(
  parameter int INDEX = 0
) (
  input  logic                                clk_i,
  input  bole_pkg::cell_cmd_t                 cmd_i,
  input  logic [bole_pkg::DataW-1:0]          left_i,
  input  logic [bole_pkg::DataW-1:0]          right_i,
  input  logic [bole_pkg::DataW-1:0]          wrap_i,
  output logic [bole_pkg::DataW-1:0]          data_o
);
  import bole_pkg::*;

  localparam logic [IdxMaxW-1:0] Me = IdxMaxW'(INDEX);

  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CMD_INS: begin
        if (Me > cmd_i.idx) begin
          data_d = left_i;
        end else if (Me == cmd_i.idx) begin
          data_d = cmd_i.value;
        end
      end
      CMD_DEL: begin
        if (Me >= cmd_i.idx) begin
          data_d = right_i;
        end
      end
      CMD_ROT: begin
        if (Me == cmd_i.last) begin
          data_d = wrap_i;
        end else if (Me < cmd_i.last) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
